/* src/pkhl_pkg.sv */
// package with types, codes and constants of the passkey hash lockout checker
package pkhl_pkg;

  localparam logic [31:0] SEED_A        = 32'h6A09E667;
  localparam logic [31:0] SEED_B        = 32'hBB67AE85;
  localparam logic [31:0] SEED_C        = 32'h3C6EF372;
  localparam logic [31:0] SEED_D        = 32'hA54FF53A;
  localparam logic [31:0] ENTROPY_RESET = 32'h5A5A5A5A;
  localparam logic [3:0]  LIMIT_RESET   = 4'd3;
  localparam logic [3:0]  FAIL_MAX      = 4'd15;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_SEED  = 2'd2;

  localparam logic [2:0] ST_GRANTED       = 3'd0;
  localparam logic [2:0] ST_WRONG_KEY     = 3'd1;
  localparam logic [2:0] ST_LOCKED        = 3'd2;
  localparam logic [2:0] ST_NAME_MISMATCH = 3'd3;
  localparam logic [2:0] ST_NEWLY_LOCKED  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] payload;
    logic        name_matches;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] failures;
    logic       locked_flag;
  } rsp_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    rotl32 = (v << s) | (v >> (32 - s));
  endfunction

endpackage

/* src/pkhl_if.sv */
// request and response channel interfaces of the passkey hash lockout checker
interface pkhl_req_if;
  import pkhl_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pkhl_rsp_if;
  import pkhl_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/passkey_hash_lockout_checker.sv */
// top level: passkey mixing, digest compare and failed attempt lockout
// a check gives its result through the request register s1_q and then the result register out_q
// throughput: one transaction per cycle unless stalled, set by the single mix and compare stage
// bytes and seeds give no result; a held result stalls only a following check
// reset: asynchronous, clears the pipeline, count and lock, loads the entropy
// word and limit with their defaults and the reference words with zero
module passkey_hash_lockout_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pkhl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pkhl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pkhl_req_if.sink                        req_i,
  pkhl_rsp_if.source                      rsp_o
);
  import pkhl_pkg::*;

  logic [63:0] ref_low_q, ref_high_q;
  logic [3:0]  limit_q;

  logic        s1_valid_q;
  req_t        s1_q;

  logic [31:0] mix_a_q, mix_b_q, mix_c_q, mix_d_q;
  logic [31:0] mix_a_d, mix_b_d, mix_c_d, mix_d_d;
  logic        started_q, started_d;
  logic [31:0] entropy_q, entropy_d;
  logic [3:0]  fail_q, fail_d;
  logic        locked_q, locked_d;

  logic        out_valid_q;
  rsp_t        out_q, out_d;

  logic        stall;
  logic        process;
  logic        is_check;
  logic [31:0] a_cur, b_cur, c_cur, d_cur;
  logic [31:0] ch;
  logic [3:0]  fail_inc;
  logic        digest_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_low_q  <= '0;
      ref_high_q <= '0;
      limit_q    <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_LOW:  ref_low_q  <= cfg_data_i;
        CFG_REF_HIGH: ref_high_q <= cfg_data_i;
        CFG_LIMIT:    limit_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign is_check    = (s1_q.req_type == REQ_CHECK);
  assign stall       = s1_valid_q && is_check && out_valid_q && !rsp_o.ready;
  assign process     = s1_valid_q && !stall;
  assign req_i.ready = !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && req_i.valid) begin
      s1_q <= req_i.data;
    end
  end

  // current words, seeded when a passkey starts
  always_comb begin
    if (started_q) begin
      a_cur = mix_a_q;
      b_cur = mix_b_q;
      c_cur = mix_c_q;
      d_cur = mix_d_q;
    end else begin
      a_cur = SEED_A ^ entropy_q;
      b_cur = SEED_B;
      c_cur = SEED_C;
      d_cur = SEED_D;
    end
  end

  assign ch        = {24'd0, s1_q.payload[7:0]};
  assign fail_inc  = (fail_q == FAIL_MAX) ? FAIL_MAX : fail_q + 4'd1;
  assign digest_ok = ({b_cur, a_cur} == ref_low_q) && ({d_cur, c_cur} == ref_high_q);

  always_comb begin
    mix_a_d   = mix_a_q;
    mix_b_d   = mix_b_q;
    mix_c_d   = mix_c_q;
    mix_d_d   = mix_d_q;
    started_d = started_q;
    entropy_d = entropy_q;
    fail_d    = fail_q;
    locked_d  = locked_q;
    out_d     = out_q;
    if (process) begin
      case (s1_q.req_type)
        REQ_BYTE: begin
          mix_a_d   = rotl32(a_cur, 5) + b_cur + ch;
          mix_b_d   = (b_cur ^ c_cur) + ch;
          mix_c_d   = rotl32(c_cur, 13);
          mix_d_d   = d_cur ^ (mix_a_d + mix_b_d);
          started_d = 1'b1;
        end
        REQ_SEED: begin
          entropy_d = entropy_q ^ s1_q.payload;
        end
        REQ_CHECK: begin
          mix_a_d   = a_cur;
          mix_b_d   = b_cur;
          mix_c_d   = c_cur;
          mix_d_d   = d_cur;
          started_d = 1'b0;
          if (locked_q) begin
            out_d.status = ST_LOCKED;
          end else if (!s1_q.name_matches) begin
            out_d.status = ST_NAME_MISMATCH;
          end else if (digest_ok) begin
            fail_d       = '0;
            out_d.status = ST_GRANTED;
          end else begin
            fail_d = fail_inc;
            if (fail_inc >= limit_q) begin
              locked_d     = 1'b1;
              out_d.status = ST_NEWLY_LOCKED;
            end else begin
              out_d.status = ST_WRONG_KEY;
            end
          end
          out_d.failures    = fail_d;
          out_d.locked_flag = locked_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_a_q     <= '0;
      mix_b_q     <= '0;
      mix_c_q     <= '0;
      mix_d_q     <= '0;
      started_q   <= 1'b0;
      entropy_q   <= ENTROPY_RESET;
      fail_q      <= '0;
      locked_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mix_a_q   <= mix_a_d;
      mix_b_q   <= mix_b_d;
      mix_c_q   <= mix_c_d;
      mix_d_q   <= mix_d_d;
      started_q <= started_d;
      entropy_q <= entropy_d;
      fail_q    <= fail_d;
      locked_q  <= locked_d;
      if (process && is_check) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // the lock holds until reset
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock released without reset");

  a_granted_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_GRANTED |-> out_q.failures == '0 && !out_q.locked_flag)
    else $error("granted result with failures or lock");

  a_new_lock_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_NEWLY_LOCKED |-> out_q.locked_flag && locked_q)
    else $error("newly locked result without lock");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && is_check))
    else $error("result without a check transaction");

  a_check_ends_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && is_check |=> !started_q)
    else $error("passkey still open after check");

endmodule
